// ===== design/input_completeness_scanner_macros.svh =====
// Assertion macros for the input completeness scanner.
`ifndef INPUT_COMPLETENESS_SCANNER_MACROS_SVH
`define INPUT_COMPLETENESS_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define ICS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed");
`define ICS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed");
`else
`define ICS_ASSERT_SAME(label, ante, cons)
`define ICS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/ics_pkg.sv =====
// Shared types and constants for the input completeness scanner.
`timescale 1ns / 1ps
package ics_pkg;

  localparam int COUNT_BITS_DEFAULT  = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACK    = 8'h5B;
  localparam logic [7:0] CH_RBRACK    = 8'h5D;

  typedef enum logic [3:0] {
    CLS_OTHER     = 4'd0,
    CLS_NEWLINE   = 4'd1,
    CLS_QUOTE     = 4'd2,
    CLS_DASH      = 4'd3,
    CLS_SLASH     = 4'd4,
    CLS_STAR      = 4'd5,
    CLS_BACKSLASH = 4'd6,
    CLS_LBRACE    = 4'd7,
    CLS_RBRACE    = 4'd8,
    CLS_LPAREN    = 4'd9,
    CLS_RPAREN    = 4'd10,
    CLS_LBRACK    = 4'd11,
    CLS_RBRACK    = 4'd12
  } char_class_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic complete;
    logic nest_overflow;
  } out_item_t;

  typedef struct packed {
    char_class_t cls;
    logic        first_byte;
  } cls_item_t;

endpackage

// ===== design/ics_front.sv =====
// Front stage: accepts bytes and registers their character class.
`timescale 1ns / 1ps
module ics_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  ics_pkg::in_item_t up_item,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ics_pkg::cls_item_t dn_item
);
  import ics_pkg::*;

  char_class_t cls;
  logic        valid;
  cls_item_t   item;

  always_comb begin
    case (up_item.text_byte)
      CH_NEWLINE:   cls = CLS_NEWLINE;
      CH_QUOTE:     cls = CLS_QUOTE;
      CH_DASH:      cls = CLS_DASH;
      CH_SLASH:     cls = CLS_SLASH;
      CH_STAR:      cls = CLS_STAR;
      CH_BACKSLASH: cls = CLS_BACKSLASH;
      CH_LBRACE:    cls = CLS_LBRACE;
      CH_RBRACE:    cls = CLS_RBRACE;
      CH_LPAREN:    cls = CLS_LPAREN;
      CH_RPAREN:    cls = CLS_RPAREN;
      CH_LBRACK:    cls = CLS_LBRACK;
      CH_RBRACK:    cls = CLS_RBRACK;
      default:      cls = CLS_OTHER;
    endcase
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item.cls        <= cls;
      item.first_byte <= up_item.first_byte;
    end
  end

endmodule

// ===== design/ics_queue.sv =====
// Small queue of classified items between front and back.
`timescale 1ns / 1ps
module ics_queue #(
  parameter int DEPTH = ics_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  ics_pkg::cls_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ics_pkg::cls_item_t dn_item
);
  import ics_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cls_item_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign up_ready = (count != FULL_COUNT);
  assign dn_valid = (count != '0);
  assign dn_item  = entries[rd_ptr];
  assign push     = up_valid && up_ready;
  assign pop      = dn_valid && dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= up_item;
    end
  end

endmodule

// ===== design/ics_back.sv =====
// Back stage: scan state machine, saturating counters and result register.
`timescale 1ns / 1ps
module ics_back #(
  parameter int COUNT_BITS = ics_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  ics_pkg::cls_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ics_pkg::out_item_t dn_item
);
  import ics_pkg::*;

  typedef enum logic [10:0] {
    M_NORMAL      = 11'b000_0000_0001,
    M_PEND_DASH   = 11'b000_0000_0010,
    M_PEND_SLASH  = 11'b000_0000_0100,
    M_PEND_QUOTE  = 11'b000_0000_1000,
    M_LINE        = 11'b000_0001_0000,
    M_BLOCK       = 11'b000_0010_0000,
    M_BLOCK_SLASH = 11'b000_0100_0000,
    M_BLOCK_STAR  = 11'b000_1000_0000,
    M_TRIPLE      = 11'b001_0000_0000,
    M_STRING      = 11'b010_0000_0000,
    M_STRING_ESC  = 11'b100_0000_0000
  } mode_t;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX   = {1'b0, {(COUNT_BITS - 1){1'b1}}};
  localparam cnt_t CNT_MIN   = {1'b1, {(COUNT_BITS - 1){1'b0}}};
  localparam cnt_t DEPTH_MAX = {COUNT_BITS{1'b1}};
  localparam cnt_t CNT_ONE   = cnt_t'(1);

  mode_t       mode;
  logic [1:0]  quote_run;
  cnt_t        depth;
  cnt_t        brace;
  cnt_t        paren;
  cnt_t        bracket;
  logic        overflow;

  mode_t       mode_cur, mode_next;
  logic [1:0]  quote_run_cur, quote_run_next;
  cnt_t        depth_cur, depth_next;
  cnt_t        brace_cur, brace_next;
  cnt_t        paren_cur, paren_next;
  cnt_t        bracket_cur, bracket_next;
  logic        overflow_cur, overflow_next;

  char_class_t cls;
  logic        do_normal, do_string, do_block;
  logic        depth_inc, depth_dec;
  logic        brace_inc, brace_dec, paren_inc, paren_dec, bracket_inc, bracket_dec;
  logic        complete_next;
  logic        take;
  logic        out_valid;
  out_item_t   out_item;

  assign cls      = up_item.cls;
  assign up_ready = !out_valid || dn_ready;
  assign take     = up_valid && up_ready;
  assign dn_valid = out_valid;
  assign dn_item  = out_item;

  // a start mark scans from the reset state
  always_comb begin
    if (up_item.first_byte) begin
      mode_cur      = M_NORMAL;
      quote_run_cur = '0;
      depth_cur     = '0;
      brace_cur     = '0;
      paren_cur     = '0;
      bracket_cur   = '0;
      overflow_cur  = 1'b0;
    end else begin
      mode_cur      = mode;
      quote_run_cur = quote_run;
      depth_cur     = depth;
      brace_cur     = brace;
      paren_cur     = paren;
      bracket_cur   = bracket;
      overflow_cur  = overflow;
    end
  end

  always_comb begin
    mode_next      = mode_cur;
    quote_run_next = quote_run_cur;
    do_normal      = 1'b0;
    do_string      = 1'b0;
    do_block       = 1'b0;
    depth_inc      = 1'b0;
    depth_dec      = 1'b0;
    brace_inc      = 1'b0;
    brace_dec      = 1'b0;
    paren_inc      = 1'b0;
    paren_dec      = 1'b0;
    bracket_inc    = 1'b0;
    bracket_dec    = 1'b0;

    unique case (mode_cur)
      M_NORMAL: begin
        quote_run_next = '0;
        do_normal      = 1'b1;
      end
      M_PEND_DASH: begin
        if (cls == CLS_DASH) mode_next = M_LINE;
        else do_normal = 1'b1;
      end
      M_PEND_SLASH: begin
        if (cls == CLS_STAR) begin
          depth_inc = 1'b1;
          mode_next = M_BLOCK;
        end else begin
          do_normal = 1'b1;
        end
      end
      M_PEND_QUOTE: begin
        if (quote_run_cur == 2'd1) begin
          if (cls == CLS_QUOTE) begin
            quote_run_next = 2'd2;
          end else begin
            quote_run_next = '0;
            do_string      = 1'b1;
          end
        end else begin
          quote_run_next = '0;
          if (cls == CLS_QUOTE) mode_next = M_TRIPLE;
          else do_normal = 1'b1;
        end
      end
      M_LINE: begin
        if (cls == CLS_NEWLINE) mode_next = M_NORMAL;
      end
      M_BLOCK: begin
        do_block = 1'b1;
      end
      M_BLOCK_SLASH: begin
        if (cls == CLS_STAR) begin
          depth_inc = 1'b1;
          mode_next = M_BLOCK;
        end else begin
          do_block = 1'b1;
        end
      end
      M_BLOCK_STAR: begin
        if (cls == CLS_SLASH) begin
          depth_dec = 1'b1;
          mode_next = (depth_cur > CNT_ONE) ? M_BLOCK : M_NORMAL;
        end else begin
          do_block = 1'b1;
        end
      end
      M_TRIPLE: begin
        if (cls == CLS_QUOTE) begin
          if (quote_run_cur >= 2'd2) begin
            mode_next      = M_NORMAL;
            quote_run_next = '0;
          end else begin
            quote_run_next = quote_run_cur + 2'd1;
          end
        end else begin
          quote_run_next = '0;
        end
      end
      M_STRING: begin
        do_string = 1'b1;
      end
      M_STRING_ESC: begin
        mode_next = M_STRING;
      end
      default: begin
        quote_run_next = '0;
        do_normal      = 1'b1;
      end
    endcase

    if (do_normal) begin
      mode_next = M_NORMAL;
      case (cls)
        CLS_QUOTE: begin
          mode_next      = M_PEND_QUOTE;
          quote_run_next = 2'd1;
        end
        CLS_DASH:   mode_next   = M_PEND_DASH;
        CLS_SLASH:  mode_next   = M_PEND_SLASH;
        CLS_LBRACE: brace_inc   = 1'b1;
        CLS_RBRACE: brace_dec   = 1'b1;
        CLS_LPAREN: paren_inc   = 1'b1;
        CLS_RPAREN: paren_dec   = 1'b1;
        CLS_LBRACK: bracket_inc = 1'b1;
        CLS_RBRACK: bracket_dec = 1'b1;
        default: ;
      endcase
    end

    if (do_string) begin
      if (cls == CLS_BACKSLASH) mode_next = M_STRING_ESC;
      else if (cls == CLS_QUOTE || cls == CLS_NEWLINE) mode_next = M_NORMAL;
      else mode_next = M_STRING;
    end

    if (do_block) begin
      if (cls == CLS_SLASH) mode_next = M_BLOCK_SLASH;
      else if (cls == CLS_STAR) mode_next = M_BLOCK_STAR;
      else mode_next = M_BLOCK;
    end
  end

  // saturating counters; a blocked step only sets the sticky flag
  always_comb begin
    overflow_next = overflow_cur;
    depth_next    = depth_cur;
    brace_next    = brace_cur;
    paren_next    = paren_cur;
    bracket_next  = bracket_cur;

    if (depth_inc) begin
      if (depth_cur == DEPTH_MAX) overflow_next = 1'b1;
      else depth_next = depth_cur + CNT_ONE;
    end else if (depth_dec && depth_cur != '0) begin
      depth_next = depth_cur - CNT_ONE;
    end

    if (brace_inc) begin
      if (brace_cur == CNT_MAX) overflow_next = 1'b1;
      else brace_next = brace_cur + CNT_ONE;
    end else if (brace_dec) begin
      if (brace_cur == CNT_MIN) overflow_next = 1'b1;
      else brace_next = brace_cur - CNT_ONE;
    end

    if (paren_inc) begin
      if (paren_cur == CNT_MAX) overflow_next = 1'b1;
      else paren_next = paren_cur + CNT_ONE;
    end else if (paren_dec) begin
      if (paren_cur == CNT_MIN) overflow_next = 1'b1;
      else paren_next = paren_cur - CNT_ONE;
    end

    if (bracket_inc) begin
      if (bracket_cur == CNT_MAX) overflow_next = 1'b1;
      else bracket_next = bracket_cur + CNT_ONE;
    end else if (bracket_dec) begin
      if (bracket_cur == CNT_MIN) overflow_next = 1'b1;
      else bracket_next = bracket_cur - CNT_ONE;
    end
  end

  // counts are non-positive when negative or zero
  assign complete_next =
      (brace_next[COUNT_BITS-1] || brace_next == '0) &&
      (paren_next[COUNT_BITS-1] || paren_next == '0) &&
      (bracket_next[COUNT_BITS-1] || bracket_next == '0) &&
      (depth_next == '0) && (mode_next != M_TRIPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_NORMAL;
      quote_run <= '0;
      depth     <= '0;
      brace     <= '0;
      paren     <= '0;
      bracket   <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        mode      <= mode_next;
        quote_run <= quote_run_next;
        depth     <= depth_next;
        brace     <= brace_next;
        paren     <= paren_next;
        bracket   <= bracket_next;
        overflow  <= overflow_next;
      end
      if (up_ready) begin
        out_valid <= up_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.complete      <= complete_next;
      out_item.nest_overflow <= overflow_next;
    end
  end

endmodule

// ===== design/input_completeness_scanner.sv =====
// Top level of the input completeness scanner.
`timescale 1ns / 1ps
// Input completeness scanner: checks bracket balance of streamed source text.
//
// Channels: item (text_byte, first_byte) in, result (complete, nest_overflow)
// out, both valid/ready. One result comes back for every item, in order.
// Set first_byte on the first byte of new text to clear all scan state.
//
// Path: the front register loads at the accepting edge; the queue entry
// and then the result register follow, and the result is valid once it
// is loaded into the result register.
// Throughput: one item per cycle while the receiver takes results; the scan
// state and counters in the back stage update once per byte, which sets the rate.
//
// When the receiver stalls, the result register holds, the back stage stops,
// the queue fills and then the front stage and item_ready drop; nothing is
// dropped and up to QUEUE_DEPTH + 2 items, four by default, sit in flight.
// Reset (rst, synchronous) empties the front stage, queue and result register
// and returns the scanner to normal mode with all counters at zero.
// Counters saturate at the COUNT_BITS limits and set the sticky nest_overflow.
`include "input_completeness_scanner_macros.svh"
module input_completeness_scanner #(
  parameter int COUNT_BITS  = ics_pkg::COUNT_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = ics_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ics_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output ics_pkg::out_item_t result
);
  import ics_pkg::*;

  // front -> queue
  logic      front_valid;
  logic      front_ready;
  cls_item_t front_item;

  // queue -> back
  logic      q_valid;
  logic      q_ready;
  cls_item_t q_item;

  ics_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (item_valid),
    .up_ready (item_ready),
    .up_item  (item),
    .dn_valid (front_valid),
    .dn_ready (front_ready),
    .dn_item  (front_item)
  );

  ics_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_item  (front_item),
    .dn_valid (q_valid),
    .dn_ready (q_ready),
    .dn_item  (q_item)
  );

  ics_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (q_valid),
    .up_ready (q_ready),
    .up_item  (q_item),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_item  (result)
  );

  // a full queue with a waiting front item must hold off new input
  `ICS_ASSERT_SAME(a_front_stall, front_valid && !front_ready, !item_ready)
  // a new result only follows an item taken from the queue
  `ICS_ASSERT_SAME(a_result_source, $rose(result_valid), $past(q_valid))
  // a start mark clears the sticky flag; one byte cannot saturate a counter
  `ICS_ASSERT_NEXT(a_start_clears, q_valid && q_ready && q_item.first_byte,
                   result_valid && !result.nest_overflow)

endmodule
